[design/dqe_pkg.sv]
// Package with the types, codes and sizes shared by the double-ended queue files.
`timescale 1ns / 1ps
`default_nettype none

package dqe_pkg;

	localparam int CAPACITY = 1024;
	localparam int PTR_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int CMD_W    = 3;
	localparam int POS_W    = 10;
	localparam int ST_W     = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_POP_BACK   = 3'd1,
		CMD_PUSH_FRONT = 3'd2,
		CMD_POP_FRONT  = 3'd3,
		CMD_READ       = 3'd4,
		CMD_WRITE      = 3'd5
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef struct packed {
		logic              we;
		logic              re;
		logic [PTR_W-1:0]  addr;
		logic [DATA_W-1:0] wdata;
	} mem_req_t;

	typedef struct packed {
		logic             is_read;
		logic [CNT_W-1:0] occupancy;
		status_t          status;
	} rsp_info_t;

endpackage

`default_nettype wire

[design/dqe_if.sv]
// Valid/ready channel interfaces for the queue's command and result transfers.
`timescale 1ns / 1ps
`default_nettype none

interface dqe_req_if;
	import dqe_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic signed [DATA_W-1:0] value;
	logic [POS_W-1:0]         position;

	modport source (output valid, cmd, value, position, input ready);
	modport sink (input valid, cmd, value, position, output ready);
endinterface

interface dqe_rsp_if;
	import dqe_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] read_data;
	logic [CNT_W-1:0]         occupancy;
	logic [ST_W-1:0]          status;

	modport source (output valid, read_data, occupancy, status, input ready);
	modport sink (input valid, read_data, occupancy, status, output ready);
endinterface

`default_nettype wire

[design/dqe_ctrl.sv]
// Front pointer and element count, command decode and store access generation.
`timescale 1ns / 1ps
`default_nettype none

module dqe_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      take,
	input  wire logic [dqe_pkg::CMD_W-1:0] cmd,
	input  wire logic [dqe_pkg::DATA_W-1:0] value,
	input  wire logic [dqe_pkg::POS_W-1:0] position,
	output dqe_pkg::mem_req_t              mem_req,
	output dqe_pkg::rsp_info_t             info
);
	import dqe_pkg::*;

	logic [PTR_W-1:0] front_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] front_d;
	logic [CNT_W-1:0] count_d;
	logic             full;
	logic             empty;
	logic             in_range;
	logic [PTR_W-1:0] pos_slot;

	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);
	assign in_range = (CNT_W'(position) < count_q);
	assign pos_slot = front_q + PTR_W'(position);

	always_comb begin
		front_d       = front_q;
		count_d       = count_q;
		mem_req.we    = 1'b0;
		mem_req.re    = 1'b0;
		mem_req.addr  = pos_slot;
		mem_req.wdata = value;
		info.is_read  = 1'b0;
		info.status   = ST_OK;
		unique case (cmd)
			CMD_PUSH_BACK: begin
				if (full) begin
					info.status = ST_FULL;
				end else begin
					mem_req.we   = take;
					mem_req.addr = front_q + count_q[PTR_W-1:0];
					count_d      = count_q + 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (empty) begin
					info.status = ST_EMPTY;
				end else begin
					count_d = count_q - 1'b1;
				end
			end
			CMD_PUSH_FRONT: begin
				if (full) begin
					info.status = ST_FULL;
				end else begin
					front_d      = front_q - 1'b1;
					mem_req.we   = take;
					mem_req.addr = front_q - 1'b1;
					count_d      = count_q + 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					info.status = ST_EMPTY;
				end else begin
					front_d = front_q + 1'b1;
					count_d = count_q - 1'b1;
				end
			end
			CMD_READ: begin
				if (!in_range) begin
					info.status = ST_RANGE;
				end else begin
					mem_req.re   = take;
					info.is_read = 1'b1;
				end
			end
			CMD_WRITE: begin
				if (!in_range) begin
					info.status = ST_RANGE;
				end else begin
					mem_req.we = take;
				end
			end
			default: begin
			end
		endcase
		info.occupancy = count_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (take) begin
			front_q <= front_d;
			count_q <= count_d;
		end
	end

endmodule

`default_nettype wire

[design/dqe_mem.sv]
// Single-port synchronous store of queue words with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module dqe_mem (
	input  wire logic                       clk,
	input  wire dqe_pkg::mem_req_t          req,
	output logic [dqe_pkg::DATA_W-1:0]      rd_data
);
	import dqe_pkg::*;

	logic [DATA_W-1:0] store_q [CAPACITY];
	logic [DATA_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			store_q[req.addr] <= req.wdata;
		end
		if (req.re) begin
			rd_q <= store_q[req.addr];
		end
	end

	assign rd_data = rd_q;

endmodule

`default_nettype wire

[design/double_ended_queue.sv]
// Top level of the double-ended queue: command channel, store, result pipeline.
//
// Usage: commands arrive as transfers on the req channel (cmd, value,
// position) and every command produces exactly one transfer on the rsp
// channel carrying read_data, occupancy and status. Commands are push or pop
// at the back or front, and read or write of the element at a position
// counted from the front. Refused commands (push when full, pop when empty,
// position beyond the count) change nothing and report the reason in status.
// A command goes from the req transfer through the synchronous store read
// and the stage register to the output register. Throughput is one command
// per cycle unless the receiver stalls, set by the single port of the store,
// which every command uses at most once. Pointer and count update at the req
// transfer, so a command sees the effect of the one before it with no bubble.
// Reset clears the front pointer, the count and both pipeline valid flags;
// the store contents are not cleared and are only read after being written.
// When the receiver stalls, the result waits in the output register, one
// more command can sit in the stage behind it, and then req.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue (
	input  wire logic clk,
	input  wire logic arst_n,
	dqe_req_if.sink   req,
	dqe_rsp_if.source rsp
);
	import dqe_pkg::*;

	mem_req_t          mem_req;
	rsp_info_t         info;
	logic [DATA_W-1:0] rd_data;
	logic              take;
	logic              advance;

	logic              valid_s1;
	rsp_info_t         info_s1;

	logic              rsp_valid_q;
	logic [DATA_W-1:0] read_data_q;
	logic [CNT_W-1:0]  occupancy_q;
	logic [ST_W-1:0]   status_q;

	// The stage moves into the output register whenever that register is
	// empty or is being drained in this cycle.
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign take      = req.valid && req.ready;

	dqe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.cmd      (req.cmd),
		.value    (req.value),
		.position (req.position),
		.mem_req  (mem_req),
		.info     (info)
	);

	// A read is issued only at a transfer, and a transfer into the stage
	// happens only when the previous item leaves it, so the read register
	// always belongs to the item currently in the stage.
	dqe_mem u_mem (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			info_s1 <= info;
		end
		if (advance) begin
			read_data_q <= info_s1.is_read ? rd_data : '0;
			occupancy_q <= info_s1.occupancy;
			status_q    <= info_s1.status;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.read_data = signed'(read_data_q);
	assign rsp.occupancy = occupancy_q;
	assign rsp.status    = status_q;

endmodule

`default_nettype wire

[design/dqe_checker.sv]
// Port-level checks on the double-ended queue, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module dqe_checker (
	input wire logic                       clk,
	input wire logic                       arst_n,
	input wire logic                       rsp_valid,
	input wire logic                       rsp_ready,
	input wire logic [dqe_pkg::DATA_W-1:0] read_data,
	input wire logic [dqe_pkg::CNT_W-1:0]  occupancy,
	input wire logic [dqe_pkg::ST_W-1:0]   status
);
	import dqe_pkg::*;

	// A pending result is not withdrawn while the receiver stalls.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> occupancy <= CNT_W'(CAPACITY))
		else $error("occupancy above capacity");

	// Refusals for full or empty must agree with the reported count.
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> occupancy == CNT_W'(CAPACITY))
		else $error("full refusal with room left");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_EMPTY || status == ST_RANGE) && occupancy == '0
		|-> read_data == '0)
		else $error("refused command returned data");

	a_empty_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_EMPTY |-> occupancy == '0)
		else $error("empty refusal with elements held");

endmodule

bind double_ended_queue dqe_checker u_dqe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.read_data (rsp.read_data),
	.occupancy (rsp.occupancy),
	.status    (rsp.status)
);

`default_nettype wire
